### rtl/ext_handler_db_matcher_defines.svh
// ----------------------------------------------------------------------------
// ext_handler_db_matcher_defines
// Assertion macros used by the checker file of the extension matcher.
// ----------------------------------------------------------------------------
`ifndef EXT_HANDLER_DB_MATCHER_DEFINES_SVH
`define EXT_HANDLER_DB_MATCHER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define EHDM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define EHDM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ehdm_pkg.sv
// ----------------------------------------------------------------------------
// ehdm_pkg
// Shared types and register indexes of the extension database matcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ehdm_pkg;

  localparam logic [1:0] REG_EXT_FIRST  = 2'd0;
  localparam logic [1:0] REG_EXT_SECOND = 2'd1;
  localparam logic [1:0] REG_EXT_THIRD  = 2'd2;
  localparam logic [1:0] REG_EXT_LENGTH = 2'd3;

  typedef struct packed {
    logic [7:0] db_byte;
    logic       db_final;
  } in_t;

  typedef struct packed {
    logic [7:0] handler_char;
    logic       is_done;
    logic       found;
  } out_t;

  typedef struct packed {
    logic [7:0] ext_first;
    logic [7:0] ext_second;
    logic [7:0] ext_third;
    logic [1:0] ext_length;
  } cfg_t;

  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } step_res_t;

endpackage

### rtl/ehdm_parser.sv
// ----------------------------------------------------------------------------
// ehdm_parser
// Per-byte parse state machine: token match, colon seek, handler capture.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ehdm_parser #(
  parameter int HANDLER_MAX = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  ehdm_pkg::in_t         req,
  input  ehdm_pkg::cfg_t        cfg,
  output ehdm_pkg::step_res_t   res
);

  localparam int CNT_W = (HANDLER_MAX > 2) ? $clog2(HANDLER_MAX) : 1;
  localparam logic [CNT_W:0] CNT_LIMIT = (CNT_W + 1)'(HANDLER_MAX - 1);

  localparam logic [2:0] MODE_TOKEN     = 3'd0;
  localparam logic [2:0] MODE_SKIPLINE  = 3'd1;
  localparam logic [2:0] MODE_SEEKCOLON = 3'd2;
  localparam logic [2:0] MODE_SKIPSPACE = 3'd3;
  localparam logic [2:0] MODE_CAPTURE   = 3'd4;
  localparam logic [2:0] MODE_DRAIN     = 3'd5;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;

  function automatic logic [7:0] lower_of(input logic [7:0] c);
    if (c >= CH_UP_A && c <= CH_UP_Z) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  logic [2:0]       mode_r, mode_nxt;
  logic [1:0]       pos_r, pos_nxt;
  logic             mis_r, mis_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [CNT_W:0] cnt_inc;
  logic [7:0]     b;
  logic           fin, eol, closed, fnd, emit, drain, tok_match;
  logic [7:0]     ext_c;

  ehdm_pkg::out_t char_res, done_res;

  assign b         = req.db_byte;
  assign fin       = req.db_final;
  assign eol       = (b == CH_CR) || (b == CH_LF);
  assign cnt_inc   = {1'b0, cnt_r} + {{CNT_W{1'b0}}, 1'b1};
  assign tok_match = (cfg.ext_length != 2'd0) && !mis_r && (pos_r == cfg.ext_length);
  assign ext_c     = (pos_r == 2'd0) ? cfg.ext_first :
                     (pos_r == 2'd1) ? cfg.ext_second : cfg.ext_third;

  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    mis_nxt  = mis_r;
    cnt_nxt  = cnt_r;
    closed   = 1'b0;
    fnd      = 1'b0;
    emit     = 1'b0;
    drain    = 1'b0;
    unique case (mode_r)
      MODE_DRAIN: begin
        drain = 1'b1;
        if (fin) begin
          mode_nxt = MODE_TOKEN;
          pos_nxt  = 2'd0;
          mis_nxt  = 1'b0;
          cnt_nxt  = '0;
        end
      end
      MODE_SKIPLINE: begin
        if (b == CH_NUL) begin
          closed = 1'b1;
        end else if (eol) begin
          mode_nxt = MODE_TOKEN;
          pos_nxt  = 2'd0;
          mis_nxt  = 1'b0;
          cnt_nxt  = '0;
        end
      end
      MODE_SEEKCOLON: begin
        if (b == CH_NUL) begin
          closed = 1'b1;
        end else if (eol) begin
          mode_nxt = MODE_TOKEN;
          pos_nxt  = 2'd0;
          mis_nxt  = 1'b0;
          cnt_nxt  = '0;
        end else if (b == CH_COLON) begin
          mode_nxt = MODE_SKIPSPACE;
        end
      end
      MODE_SKIPSPACE, MODE_CAPTURE: begin
        if (b == CH_NUL || eol) begin
          closed = 1'b1;
          fnd    = 1'b1;
        end else if (mode_r == MODE_SKIPSPACE && b == CH_SPACE) begin
          mode_nxt = mode_r;
        end else begin
          mode_nxt = MODE_CAPTURE;
          emit     = 1'b1;
          cnt_nxt  = cnt_inc[CNT_W-1:0];
          if (cnt_inc >= CNT_LIMIT) begin
            closed = 1'b1;
            fnd    = 1'b1;
          end
        end
      end
      default: begin
        if (b == CH_NUL) begin
          closed = 1'b1;
        end else if (eol) begin
          mode_nxt = MODE_TOKEN;
          pos_nxt  = 2'd0;
          mis_nxt  = 1'b0;
          cnt_nxt  = '0;
        end else if (b == CH_COMMA) begin
          if (tok_match) begin
            mode_nxt = MODE_SEEKCOLON;
          end else begin
            pos_nxt = 2'd0;
            mis_nxt = 1'b0;
          end
        end else if (b == CH_COLON) begin
          mode_nxt = tok_match ? MODE_SKIPSPACE : MODE_SKIPLINE;
        end else if (pos_r < cfg.ext_length && lower_of(b) == lower_of(ext_c)) begin
          pos_nxt = pos_r + 2'd1;
        end else begin
          mis_nxt = 1'b1;
        end
      end
    endcase

    if (!drain) begin
      if (!closed && fin) begin
        closed = 1'b1;
        fnd    = (mode_nxt == MODE_SKIPSPACE) || (mode_nxt == MODE_CAPTURE);
      end
      if (closed) begin
        mode_nxt = fin ? MODE_TOKEN : MODE_DRAIN;
        pos_nxt  = 2'd0;
        mis_nxt  = 1'b0;
        cnt_nxt  = '0;
      end
    end
  end

  always_comb begin
    char_res.handler_char = b;
    char_res.is_done      = 1'b0;
    char_res.found        = 1'b0;
    done_res.handler_char = 8'h00;
    done_res.is_done      = 1'b1;
    done_res.found        = fnd;
    res.second            = done_res;
    if (emit) begin
      res.first = char_res;
    end else begin
      res.first = done_res;
    end
    if (!step_en) begin
      res.count = 2'd0;
    end else begin
      res.count = {1'b0, emit} + {1'b0, closed && !drain};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TOKEN;
      pos_r  <= 2'd0;
      mis_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (step_en) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      mis_r  <= mis_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

### rtl/ehdm_result_queue.sv
// ----------------------------------------------------------------------------
// ehdm_result_queue
// Four-entry result queue; takes up to two results a cycle, returns one unless out_stall holds it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ehdm_result_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  ehdm_pkg::step_res_t res,
  output logic                space_low,
  output logic                out_valid,
  input  logic                out_stall,
  output ehdm_pkg::out_t      out_data
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  ehdm_pkg::out_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]    count_r, count_nxt;
  logic           pop;

  assign out_valid  = (count_r != '0);
  assign out_data   = mem_r[rd_ptr_r];
  assign pop        = out_valid && !out_stall;
  assign space_low  = (count_r > (AW + 1)'(DEPTH - 2));
  assign wr_ptr_nxt = wr_ptr_r + AW'(res.count);
  assign rd_ptr_nxt = rd_ptr_r + AW'(pop);
  assign count_nxt  = count_r + (AW + 1)'(res.count) - (AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (res.count != 2'd0) begin
      mem_r[wr_ptr_r] <= res.first;
    end
    if (res.count == 2'd2) begin
      mem_r[wr_ptr_r + AW'(1)] <= res.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### rtl/ext_handler_db_matcher.sv
// ----------------------------------------------------------------------------
// ext_handler_db_matcher
// Streams database bytes and reports the handler of a configured extension.
// ----------------------------------------------------------------------------
// A byte's results are registered in the result queue and shown on the out port from there.
// Throughput: one byte per cycle while the input is not stalled; a byte yields zero, one or two results.
// Input stalls while fewer than two of the four result queue slots are free.
// Reset (synchronous, rst_n low) clears parse state, queue and registers.
`timescale 1ns / 1ps

module ext_handler_db_matcher #(
  parameter int HANDLER_MAX = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ehdm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ehdm_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [7:0]     cfg_data
);

  ehdm_pkg::cfg_t      cfg_r, cfg_nxt;
  ehdm_pkg::step_res_t res;
  logic                space_low;
  logic                step_en;

  assign cfg_ready = 1'b1;
  assign in_stall  = space_low;
  assign step_en   = in_valid && !space_low;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        ehdm_pkg::REG_EXT_FIRST:  cfg_nxt.ext_first  = cfg_data;
        ehdm_pkg::REG_EXT_SECOND: cfg_nxt.ext_second = cfg_data;
        ehdm_pkg::REG_EXT_THIRD:  cfg_nxt.ext_third  = cfg_data;
        ehdm_pkg::REG_EXT_LENGTH: cfg_nxt.ext_length = cfg_data[1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ehdm_parser #(
    .HANDLER_MAX(HANDLER_MAX)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_en(step_en),
    .req    (in_data),
    .cfg    (cfg_r),
    .res    (res)
  );

  ehdm_result_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .space_low(space_low),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

### rtl/ehdm_checker.sv
// ----------------------------------------------------------------------------
// ehdm_checker
// Port-level checks of the extension matcher, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ext_handler_db_matcher_defines.svh"

module ehdm_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input ehdm_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input ehdm_pkg::out_t out_data
);

  `EHDM_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data), "stalled request changed")
  `EHDM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `EHDM_ASSERT_NOW(a_char_not_found, out_valid && !out_data.is_done, !out_data.found, "character result flagged found")
  `EHDM_ASSERT_NOW(a_done_no_char, out_valid && out_data.is_done, out_data.handler_char == 8'h00, "closing result carries a character")

endmodule

bind ext_handler_db_matcher ehdm_checker u_ehdm_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
